// File: rtl/motor_can_feedback_monitor_unit_assert.svh
// Assertion macros for the motor CAN feedback monitor.
`ifndef MOTOR_CAN_FEEDBACK_MONITOR_UNIT_ASSERT_SVH
`define MOTOR_CAN_FEEDBACK_MONITOR_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MCFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MCFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/mcfm_pkg.sv
package mcfm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegLeftId    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRightId   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLeftNeg   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRightNeg  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVelScale  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLossLimit = 3'd5;

  localparam logic [10:0] LeftIdRst    = 11'd1;
  localparam logic [10:0] RightIdRst   = 11'd2;
  localparam logic [31:0] VelScaleRst  = 32'h0001_0000;
  localparam logic [7:0]  LossLimitRst = 8'd10;

  localparam logic [7:0] TypeFeedback = 8'h88;
  localparam logic [7:0] TypeFault    = 8'hFF;
  localparam logic [7:0] TagCurrent   = 8'hE2;
  localparam logic [7:0] TagVelocity  = 8'hE4;
  localparam logic [7:0] MissedMax    = 8'hFF;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StLost  = 2'd1;
  localparam logic [1:0] StFault = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [10:0] frame_id;
    logic [7:0]  type_byte;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic [7:0]  data_byte6;
    logic [7:0]  data_byte7;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [18:0]        fault_code;
    logic               disable_request;
    logic signed [15:0] left_current;
    logic signed [15:0] right_current;
    logic signed [47:0] left_velocity;
    logic signed [47:0] right_velocity;
  } out_t;

endpackage

// File: rtl/mcfm_if.sv
interface mcfm_in_if;
  logic           valid;
  logic           ready;
  mcfm_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcfm_out_if;
  logic           valid;
  logic           ready;
  mcfm_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/motor_can_feedback_monitor_unit.sv
// Two-motor CAN feedback monitor. One word in per received frame or empty poll,
// one result word out per input word, in order. A word passes an input register
// and a single decode/multiply stage into the result register; a new word is
// taken every cycle while the result side keeps up. The 16x32 velocity multiply
// sits in that one stage. Empty polls count up a saturating miss counter (lost
// status once it reaches loss_limit); any frame clears it. Current and velocity
// fields always show the stored values after the word is applied. Users write
// registers through cfg_* only while idle; the block does not enforce this.
module motor_can_feedback_monitor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcfm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mcfm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  mcfm_in_if.sink                           in_i,
  mcfm_out_if.source                        out_o
);

  // config
  logic [10:0] left_id_q, right_id_q;
  logic        left_neg_q, right_neg_q;
  logic [31:0] vel_scale_q;
  logic [7:0]  loss_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_id_q    <= mcfm_pkg::LeftIdRst;
      right_id_q   <= mcfm_pkg::RightIdRst;
      left_neg_q   <= 1'b0;
      right_neg_q  <= 1'b0;
      vel_scale_q  <= mcfm_pkg::VelScaleRst;
      loss_limit_q <= mcfm_pkg::LossLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcfm_pkg::RegLeftId:    left_id_q    <= cfg_wdata_i[10:0];
        mcfm_pkg::RegRightId:   right_id_q   <= cfg_wdata_i[10:0];
        mcfm_pkg::RegLeftNeg:   left_neg_q   <= cfg_wdata_i[0];
        mcfm_pkg::RegRightNeg:  right_neg_q  <= cfg_wdata_i[0];
        mcfm_pkg::RegVelScale:  vel_scale_q  <= cfg_wdata_i[31:0];
        mcfm_pkg::RegLossLimit: loss_limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  mcfm_pkg::in_t  in_q;
  mcfm_pkg::out_t out_q, out_d;
  logic           in_vld_q, out_vld_q;
  logic           adv, in_rdy, in_take;

  assign adv     = !out_vld_q || out_o.ready;
  assign in_rdy  = !in_vld_q || adv;
  assign in_take = in_i.valid && in_rdy;
  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // state
  logic [7:0]         missed_q, missed_d;
  logic signed [15:0] cur_l_q, cur_r_q, cur_l_d, cur_r_d;
  logic signed [47:0] vel_l_q, vel_r_q, vel_l_d, vel_r_d;

  // decode
  logic               poll, hit_l, hit_r, hit, fb, flt;
  logic [7:0]         missed_inc;
  logic [15:0]        code_a, code_b, cur_code, vel_code;
  logic               cur_upd, vel_upd, neg;
  logic signed [48:0] prod;
  logic signed [47:0] vel_val;

  always_comb begin
    poll       = in_q.cmd;
    missed_inc = (missed_q == mcfm_pkg::MissedMax) ? missed_q : missed_q + 8'd1;
    hit_l      = in_q.frame_id == left_id_q;
    hit_r      = !hit_l && (in_q.frame_id == right_id_q);
    hit        = !poll && (hit_l || hit_r);
    fb         = hit && (in_q.type_byte == mcfm_pkg::TypeFeedback);
    flt        = hit && (in_q.type_byte == mcfm_pkg::TypeFault);
    code_a     = {in_q.data_byte3, in_q.data_byte4};
    code_b     = {in_q.data_byte6, in_q.data_byte7};

    // second sub-field wins on equal tags
    cur_upd  = fb && (in_q.data_byte5 == mcfm_pkg::TagCurrent ||
                      in_q.data_byte2 == mcfm_pkg::TagCurrent);
    cur_code = (in_q.data_byte5 == mcfm_pkg::TagCurrent) ? code_b : code_a;
    vel_upd  = fb && (in_q.data_byte5 == mcfm_pkg::TagVelocity ||
                      in_q.data_byte2 == mcfm_pkg::TagVelocity);
    vel_code = (in_q.data_byte5 == mcfm_pkg::TagVelocity) ? code_b : code_a;

    prod    = $signed(vel_code) * $signed({1'b0, vel_scale_q});
    neg     = hit_r ? right_neg_q : left_neg_q;
    vel_val = neg ? -prod[47:0] : prod[47:0];

    missed_d = poll ? missed_inc : 8'd0;
    cur_l_d  = (cur_upd && hit_l) ? $signed(cur_code) : cur_l_q;
    cur_r_d  = (cur_upd && hit_r) ? $signed(cur_code) : cur_r_q;
    vel_l_d  = (vel_upd && hit_l) ? vel_val : vel_l_q;
    vel_r_d  = (vel_upd && hit_r) ? vel_val : vel_r_q;

    out_d.status          = mcfm_pkg::StOk;
    out_d.fault_code      = '0;
    out_d.disable_request = 1'b0;
    if (poll && (missed_inc >= loss_limit_q)) begin
      out_d.status = mcfm_pkg::StLost;
    end else if (flt) begin
      out_d.status          = mcfm_pkg::StFault;
      out_d.fault_code      = {in_q.frame_id, in_q.data_byte4};
      out_d.disable_request = 1'b1;
    end
    out_d.left_current   = cur_l_d;
    out_d.right_current  = cur_r_d;
    out_d.left_velocity  = vel_l_d;
    out_d.right_velocity = vel_r_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      missed_q  <= '0;
      cur_l_q   <= '0;
      cur_r_q   <= '0;
      vel_l_q   <= '0;
      vel_r_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      if (adv && in_vld_q) begin
        missed_q <= missed_d;
        cur_l_q  <= cur_l_d;
        cur_r_q  <= cur_r_d;
        vel_l_q  <= vel_l_d;
        vel_r_q  <= vel_r_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i.data;
    end
    if (adv && in_vld_q) begin
      out_q <= out_d;
    end
  end

  `include "motor_can_feedback_monitor_unit_assert.svh"

  `MCFM_ASSERT(a_ready_when_out_free, !out_vld_q |-> in_rdy, "input stalled with free output")
  `MCFM_ASSERT(a_lost_needs_miss,
    out_vld_q && out_q.status == mcfm_pkg::StLost |-> missed_q != 8'd0,
    "lost reported with clear miss counter")
  `MCFM_ASSERT(a_miss_step,
    missed_q != $past(missed_q) |-> missed_q == 8'd0 || missed_q == $past(missed_q) + 8'd1,
    "miss counter jumped")
  `MCFM_ASSERT(a_fault_fields,
    out_vld_q && out_q.status != mcfm_pkg::StFault |->
      out_q.fault_code == '0 && !out_q.disable_request,
    "fault fields set outside a fault")
  `MCFM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_vld_q && !in_vld_q, "pipeline not empty")

endmodule
